FILE: hw/rtl/mpeg2_motion_vector_decoder_macros.svh
// Assertion macros for the motion vector decoder.
`ifndef MPEG2_MOTION_VECTOR_DECODER_MACROS_SVH
`define MPEG2_MOTION_VECTOR_DECODER_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define MVD_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define MVD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/mvd_pkg.sv
// Shared types, codes and helper functions for the motion vector decoder.
`default_nettype none

package mvd_pkg;

  localparam int unsigned VecW     = 13;  // vector component width
  localparam int unsigned RsizeW   = 4;   // r_size, 0..8
  localparam int unsigned McW      = 6;   // motion_code width
  localparam int unsigned ResidW   = 8;   // motion_residual width
  localparam int unsigned SlotW    = 3;   // predictor slot {r, s, t}
  localparam int unsigned NumSlots = 8;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 4;

  localparam logic [RsizeW-1:0] RsizeMax = 4'd8;

  typedef enum logic [CfgIdxW-1:0] {
    REG_FCODE_FWD_HORIZ = 3'd0,
    REG_FCODE_FWD_VERT  = 3'd1,
    REG_FCODE_BWD_HORIZ = 3'd2,
    REG_FCODE_BWD_VERT  = 3'd3,
    REG_CONCEALMENT     = 3'd4
  } cfg_reg_t;

  typedef enum logic {
    ACT_HEADER    = 1'b0,
    ACT_COMPONENT = 1'b1
  } action_t;

  typedef logic signed [VecW-1:0] vec_t;

  // Predictor store update for one cycle.
  typedef struct packed {
    logic                 clear;   // zero all predictors
    logic                 wr_en;   // write value at slot
    logic                 wr_dup;  // also write the r=1 copy
    logic [SlotW-1:0]     slot;
    vec_t                 value;
  } pred_upd_t;

  // f_code to r_size, with f_code 0 taken as 1 and above 9 as 9.
  function automatic logic [RsizeW-1:0] fcode_to_rsize(input logic [CfgDataW-1:0] fcode);
    logic [RsizeW-1:0] rs;
    if (fcode == 4'd0) begin
      rs = 4'd0;
    end else if (fcode > 4'd9) begin
      rs = RsizeMax;
    end else begin
      rs = fcode - 4'd1;
    end
    return rs;
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/mvd_pred_store.sv
// Eight motion vector predictors PMV[r][s][t] with clear and write-back.
`default_nettype none

module mvd_pred_store
  import mvd_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic [SlotW-1:0] rd_slot,
  output vec_t                  rd_value,
  input  wire pred_upd_t        upd
);

  vec_t pred [NumSlots];

  assign rd_value = pred[rd_slot];

  always_ff @(posedge clk) begin
    if (rst || upd.clear) begin
      for (int i = 0; i < NumSlots; i++) begin
        pred[i] <= '0;
      end
    end else if (upd.wr_en) begin
      pred[upd.slot] <= upd.value;
      // frame prediction: first vector also seeds the second
      if (upd.wr_dup) begin
        pred[{1'b1, upd.slot[SlotW-2:0]}] <= upd.value;
      end
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/mvd_component_calc.sv
// Rebuilds one vector component from its motion code and residual and wraps it.
`default_nettype none

module mvd_component_calc
  import mvd_pkg::*;
(
  input  wire logic [RsizeW-1:0]     rsize,
  input  wire logic signed [McW-1:0] mv_code,
  input  wire logic [ResidW-1:0]     motion_residual,
  input  wire vec_t                  pred,
  output vec_t                       value
);

  logic signed [McW-1:0] mc_sat;
  logic                  neg;
  logic [4:0]            mag;
  logic [3:0]            mag_m1;
  logic [11:0]           scaled;
  logic [ResidW-1:0]     res_mask;
  logic [12:0]           abs_delta;
  logic [13:0]           delta;
  logic [14:0]           sum;
  logic [14:0]           keep_mask;
  logic [3:0]            sign_pos;
  logic [14:0]           wrapped;

  always_comb begin
    if (mv_code < -6'sd16) begin
      mc_sat = -6'sd16;
    end else if (mv_code > 6'sd16) begin
      mc_sat = 6'sd16;
    end else begin
      mc_sat = mv_code;
    end
    neg = mc_sat[McW-1];
    mag = neg ? 5'(-mc_sat) : 5'(mc_sat);
    mag_m1 = 4'(mag - 5'd1);
    scaled = {8'd0, mag_m1} << rsize;
    res_mask = 8'((9'd1 << rsize) - 9'd1);
    abs_delta = 13'(scaled) + 13'(motion_residual & res_mask) + 13'd1;
    if (mag == 5'd0) begin
      delta = '0;
    end else if (neg) begin
      delta = 14'd0 - {1'b0, abs_delta};
    end else begin
      delta = {1'b0, abs_delta};
    end
    sum = {{2{pred[VecW-1]}}, pred} + {delta[13], delta};
    // reduce modulo 32f: keep r_size+5 bits and sign-extend from the top one
    keep_mask = 15'((16'd1 << (rsize + 4'd5)) - 16'd1);
    sign_pos = rsize + 4'd4;
    wrapped = sum[sign_pos] ? (sum | ~keep_mask) : (sum & keep_mask);
    value = wrapped[VecW-1:0];
  end

endmodule

`default_nettype wire

FILE: hw/rtl/mpeg2_motion_vector_decoder.sv
// MPEG-2 motion vector decoder: input register, predictor update, result register.
// Takes one transaction per clock unless a component waits on a stalled output.
// A component transaction is computed from the input register and its result is
// loaded into the result register as it advances; a header yields none and may
// clear the eight predictors. Rate is set by the predictor loop: read, add, wrap
// and write-back all happen in the cycle between the input register and the
// result register, so the next component sees the updated predictor with no
// bubble. Configuration writes take effect at once and belong only to idle periods.
`default_nettype none

`include "mpeg2_motion_vector_decoder_macros.svh"

module mpeg2_motion_vector_decoder
  import mvd_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                cfg_we,
  input  wire logic [CfgIdxW-1:0]  cfg_index,
  input  wire logic [CfgDataW-1:0] cfg_data,
  input  wire logic                s_axis_tvalid,
  output      logic                s_axis_tready,
  // new_slice, is_intra, motion_fwd, motion_bwd, addr_increment[7:0],
  // mv_code[5:0], motion_residual[7:0], vec_index, vec_dir, vec_comp, pad
  input  wire logic [31:0]         s_axis_tdata,
  // action
  input  wire logic                s_axis_tuser,
  output      logic                m_axis_tvalid,
  input  wire logic                m_axis_tready,
  // vector_value[12:0], out_index, out_dir, out_comp
  output      logic [15:0]         m_axis_tdata
);

  // configuration
  logic [RsizeW-1:0] rsize [4];
  logic              conceal;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 4; i++) begin
        rsize[i] <= '0;
      end
      conceal <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_FCODE_FWD_HORIZ: rsize[0] <= fcode_to_rsize(cfg_data);
        REG_FCODE_FWD_VERT:  rsize[1] <= fcode_to_rsize(cfg_data);
        REG_FCODE_BWD_HORIZ: rsize[2] <= fcode_to_rsize(cfg_data);
        REG_FCODE_BWD_VERT:  rsize[3] <= fcode_to_rsize(cfg_data);
        REG_CONCEALMENT:     conceal <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // input register
  logic                  in_valid;
  action_t               in_action;
  logic                  in_new_slice;
  logic                  in_is_intra;
  logic                  in_motion_fwd;
  logic [7:0]            in_addr_inc;
  logic signed [McW-1:0] in_motion_code;
  logic [ResidW-1:0]     in_residual;
  logic [SlotW-1:0]      in_slot;     // {r, s, t}
  logic                  advance;
  logic                  s_accept;

  assign s_accept = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_accept) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_accept) begin
      in_action      <= action_t'(s_axis_tuser);
      in_new_slice   <= s_axis_tdata[0];
      in_is_intra    <= s_axis_tdata[1];
      in_motion_fwd  <= s_axis_tdata[2];
      in_addr_inc    <= s_axis_tdata[11:4];
      in_motion_code <= s_axis_tdata[17:12];
      in_residual    <= s_axis_tdata[25:18];
      in_slot        <= {s_axis_tdata[26], s_axis_tdata[27], s_axis_tdata[28]};
    end
  end

  // a header never needs the result register
  logic is_comp;
  assign is_comp = in_action == ACT_COMPONENT;
  assign advance = in_valid && (!is_comp || !m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;

  // component arithmetic
  vec_t pred_rd;
  vec_t comp_value;

  mvd_component_calc u_calc (
    .rsize           (rsize[in_slot[1:0]]),
    .mv_code         (in_motion_code),
    .motion_residual (in_residual),
    .pred            (pred_rd),
    .value           (comp_value)
  );

  logic      hdr_clear;
  pred_upd_t upd;

  assign hdr_clear = in_new_slice || (in_is_intra && !conceal)
                  || (!in_is_intra && !in_motion_fwd) || (in_addr_inc > 8'd1);

  always_comb begin
    upd.clear  = advance && !is_comp && hdr_clear;
    upd.wr_en  = advance && is_comp;
    upd.wr_dup = !in_slot[SlotW-1];
    upd.slot   = in_slot;
    upd.value  = comp_value;
  end

  mvd_pred_store u_store (
    .clk      (clk),
    .rst      (rst),
    .rd_slot  (in_slot),
    .rd_value (pred_rd),
    .upd      (upd)
  );

  // result register
  logic load_out;
  assign load_out = advance && is_comp;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (load_out) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      m_axis_tdata <= {in_slot[0], in_slot[1], in_slot[2], comp_value};
    end
  end

  `MVD_ASSERT_NEXT(a_result_matches_calc, load_out, m_axis_tdata[VecW-1:0] == $past(comp_value), "result register does not hold the computed component")
  `MVD_ASSERT_NEXT(a_header_no_result, advance && !is_comp && (!m_axis_tvalid || m_axis_tready), !m_axis_tvalid, "header transaction produced a result")
  `MVD_ASSERT_SAME(a_rsize_range, 1'b1, rsize[0] <= RsizeMax && rsize[1] <= RsizeMax && rsize[2] <= RsizeMax && rsize[3] <= RsizeMax, "r_size out of range")

endmodule

`default_nettype wire
